// ===== rtl/zcbm_pkg.sv =====
// Package for the zero-crossing band mask block: payload types, codes, sign helpers.
// No dependencies; zcbm_store, zcbm_seq and the top level import it.
`timescale 1ns / 1ps

package zcbm_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_COMPUTE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [1:0] CFG_RADIUS = 2'd3;

    // map word bit per pass: cell hit, z-dilated, y-dilated, update flag
    localparam logic [1:0] PASS_HIT = 2'd0;
    localparam logic [1:0] PASS_Z   = 2'd1;
    localparam logic [1:0] PASS_Y   = 2'd2;
    localparam logic [1:0] PASS_X   = 2'd3;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [4:0]                    pos_x;
        logic [4:0]                    pos_y;
        logic [4:0]                    pos_z;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in;

    typedef struct packed {
        logic update_flag;
        logic coord_error;
    } t_out;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_dist;

    typedef struct packed {
        logic dist_we;
        logic dist_re;
        logic map_we;
        logic map_re;
    } t_mem_ctl;

    function automatic logic crosses(input t_dist a, input t_dist b);
        return a.zero | b.zero | (a.neg ^ b.neg);
    endfunction

    function automatic t_dist dist_of(input logic signed [SAMPLE_BITS-1:0] s);
        t_dist d;
        d.neg  = s[SAMPLE_BITS-1];
        d.zero = (s == '0);
        return d;
    endfunction

endpackage

// ===== rtl/zcbm_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat of type T.
// Depends on nothing; payload types come from zcbm_pkg at instantiation.
`timescale 1ns / 1ps

interface zcbm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/zcbm_store.sv =====
// Voxel storage: sign store (written by host) and map store (read-modify-write by sweep).
// Both memories have one write port and one registered read port. Uses zcbm_pkg.
`timescale 1ns / 1ps

module zcbm_store #(
    parameter int VA = 15
) (
    input  logic              i_clk,
    input  zcbm_pkg::t_mem_ctl i_ctl,
    input  logic [VA-1:0]     i_dist_waddr,
    input  zcbm_pkg::t_dist   i_dist_wdata,
    input  logic [VA-1:0]     i_dist_raddr,
    output zcbm_pkg::t_dist   o_dist_q,
    input  logic [VA-1:0]     i_map_waddr,
    input  logic [3:0]        i_map_wdata,
    input  logic [VA-1:0]     i_map_raddr,
    output logic [3:0]        o_map_q
);
    import zcbm_pkg::*;

    localparam int DEPTH = 1 << VA;

    t_dist      r_dist [DEPTH];
    logic [3:0] r_map  [DEPTH];
    t_dist      r_dist_q;
    logic [3:0] r_map_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.dist_we) begin
            r_dist[i_dist_waddr] <= i_dist_wdata;
        end
        if (i_ctl.dist_re) begin
            r_dist_q <= r_dist[i_dist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.map_we) begin
            r_map[i_map_waddr] <= i_map_wdata;
        end
        if (i_ctl.map_re) begin
            r_map_q <= r_map[i_map_raddr];
        end
    end

    assign o_dist_q = r_dist_q;
    assign o_map_q  = r_map_q;

endmodule

// ===== rtl/zcbm_seq.sv =====
// Compute sweep: four passes over the volume (cell hit, then box dilation along z, y, x).
// Issues one memory read per cycle while issuing taps and writes each voxel's map word back. Uses zcbm_pkg.
`timescale 1ns / 1ps

module zcbm_seq #(
    parameter int MAX_DIM = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [8:0]                  i_eff_x,
    input  logic [8:0]                  i_eff_y,
    input  logic [8:0]                  i_eff_z,
    input  logic [1:0]                  i_radius,
    output logic                        o_done,
    output zcbm_pkg::t_mem_ctl          o_ctl,
    output logic [3*$clog2(MAX_DIM)-1:0] o_raddr,
    output logic [3*$clog2(MAX_DIM)-1:0] o_waddr,
    output logic [3:0]                  o_wdata,
    input  zcbm_pkg::t_dist             i_dist_q,
    input  logic [3:0]                  i_map_q
);
    import zcbm_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int EW = AW + 1;
    localparam int TW = AW + 2;
    localparam logic [AW-1:0] LAST = AW'(MAX_DIM - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_pass;
    logic [AW-1:0] r_x, r_y, r_z;
    logic [2:0]    r_tap;
    logic          r_dv;
    logic [2:0]    r_dtap;
    logic          r_dtv;
    logic          r_dcen;
    logic          r_acc;
    t_dist         r_first;
    logic [3:0]    r_cen;

    logic [EW-1:0]        ex, ey, ez, eff_axis;
    logic [2:0]           ntaps_m1;
    logic signed [4:0]    off;
    logic [AW-1:0]        base;
    logic signed [TW-1:0] tc;
    logic                 tap_ok;
    logic                 is_cen;
    logic [AW-1:0]        ax, ay, az;
    logic                 contrib, acc_now, org_ok, vox_ok, last_vox;
    logic [3:0]           cen_now, wd;

    assign ex = i_eff_x[AW:0];
    assign ey = i_eff_y[AW:0];
    assign ez = i_eff_z[AW:0];

    always_comb begin
        ntaps_m1 = (r_pass == PASS_HIT) ? 3'd7 : {i_radius, 1'b1};
        off      = $signed({2'b0, r_tap}) - $signed({3'b0, i_radius}) - 5'sd1;
        case (r_pass)
            PASS_Z:  begin base = r_z; eff_axis = ez; end
            PASS_Y:  begin base = r_y; eff_axis = ey; end
            default: begin base = r_x; eff_axis = ex; end
        endcase
        tc     = $signed({2'b0, base}) + TW'(off);
        tap_ok = !tc[TW-1] && (tc < $signed({1'b0, eff_axis}));
        is_cen = (r_tap == ({1'b0, i_radius} + 3'd1));
        ax = r_x;
        ay = r_y;
        az = r_z;
        case (r_pass)
            PASS_HIT: begin
                ax = r_x + AW'(r_tap[2]);
                ay = r_y + AW'(r_tap[1]);
                az = r_z + AW'(r_tap[0]);
            end
            PASS_Z:  az = tc[AW-1:0];
            PASS_Y:  ay = tc[AW-1:0];
            default: ax = tc[AW-1:0];
        endcase
    end

    always_comb begin
        if (r_pass == PASS_HIT) begin
            contrib = (r_dtap != 3'd0) && crosses(r_first, i_dist_q);
        end else begin
            contrib = r_dtv & i_map_q[r_pass - 2'd1];
        end
        acc_now  = r_acc | (r_dv & contrib);
        cen_now  = (r_dv && r_dcen) ? i_map_q : r_cen;
        org_ok   = (({1'b0, r_x} + EW'(1)) < ex) && (({1'b0, r_y} + EW'(1)) < ey)
                && (({1'b0, r_z} + EW'(1)) < ez);
        vox_ok   = ({1'b0, r_x} < ex) && ({1'b0, r_y} < ey) && ({1'b0, r_z} < ez);
        last_vox = (r_x == LAST) && (r_y == LAST) && (r_z == LAST);
        if (r_pass == PASS_HIT) begin
            wd = {3'b0, acc_now & org_ok};
        end else begin
            wd         = cen_now;
            wd[r_pass] = acc_now & vox_ok;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_ISSUE;
            S_ISSUE: if (r_tap == ntaps_m1) n_state = S_FIN;
            S_FIN:   n_state = (last_vox && r_pass == PASS_X) ? S_IDLE : S_ISSUE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_pass  <= PASS_HIT;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == S_ISSUE);
            if (r_state == S_IDLE && i_start) begin
                r_pass <= PASS_HIT;
            end else if (r_state == S_FIN && last_vox) begin
                r_pass <= r_pass + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dtap <= r_tap;
        r_dtv  <= tap_ok;
        r_dcen <= is_cen;
        if (r_dv && r_pass == PASS_HIT && r_dtap == 3'd0) begin
            r_first <= i_dist_q;
        end
        if (r_dv && r_dcen) begin
            r_cen <= i_map_q;
        end
        case (r_state)
            S_IDLE: begin
                r_x   <= '0;
                r_y   <= '0;
                r_z   <= '0;
                r_tap <= '0;
                r_acc <= 1'b0;
            end
            S_ISSUE: begin
                r_tap <= r_tap + 3'd1;
                r_acc <= acc_now;
            end
            default: begin
                r_tap <= '0;
                r_acc <= 1'b0;
                if (r_z == LAST) begin
                    r_z <= '0;
                    if (r_y == LAST) begin
                        r_y <= '0;
                        r_x <= (r_x == LAST) ? '0 : r_x + AW'(1);
                    end else begin
                        r_y <= r_y + AW'(1);
                    end
                end else begin
                    r_z <= r_z + AW'(1);
                end
            end
        endcase
    end

    assign o_ctl.dist_we = 1'b0;
    assign o_ctl.dist_re = (r_state == S_ISSUE) && (r_pass == PASS_HIT);
    assign o_ctl.map_re  = (r_state == S_ISSUE) && (r_pass != PASS_HIT);
    assign o_ctl.map_we  = (r_state == S_FIN);
    assign o_raddr       = {ax, ay, az};
    assign o_waddr       = {r_x, r_y, r_z};
    assign o_wdata       = wd;
    assign o_done        = (r_state == S_FIN) && last_vox && (r_pass == PASS_X);

endmodule

// ===== rtl/zero_crossing_band_mask_3d_unit.sv =====
// Voxel writes and update-flag reads take one beat in and one beat out: a write's result is
// registered in the cycle after it is accepted, a read's result passes the registered memory
// read and the read state first. A compute beat sweeps the whole MAX_DIM^3 store four times,
// one memory access per cycle. Every beat gives one result.
// Top level; depends on zcbm_pkg, zcbm_stream_if, zcbm_store and zcbm_seq.
`timescale 1ns / 1ps

module zero_crossing_band_mask_3d_unit #(
    parameter int MAX_DIM = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zcbm_stream_if.sink   i_in,
    zcbm_stream_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);
    import zcbm_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int VA = 3 * AW;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_COMP = 2'd1;
    localparam logic [1:0] T_CEND = 2'd2;
    localparam logic [1:0] T_READ = 2'd3;

    logic [5:0] r_size_x, r_size_y, r_size_z;
    logic [1:0] r_radius;
    logic [1:0] r_st, n_st;
    logic       r_ov, n_ov;
    t_out       r_out, n_out;
    logic       r_rd_in;
    logic       r_map_ok;

    logic [8:0]    eff_x, eff_y, eff_z;
    logic          in_vol, acc_in, slot_free;
    logic [VA-1:0] host_addr;
    t_mem_ctl      seq_ctl, mem_ctl;
    logic          seq_done;
    logic [VA-1:0] seq_raddr, seq_waddr;
    logic [3:0]    seq_wdata, map_q;
    t_dist         dist_q;

    function automatic logic [8:0] eff_of(input logic [5:0] s);
        return ({3'b0, s} > 9'(MAX_DIM)) ? 9'(MAX_DIM) : {3'b0, s};
    endfunction

    assign eff_x     = eff_of(r_size_x);
    assign eff_y     = eff_of(r_size_y);
    assign eff_z     = eff_of(r_size_z);
    assign in_vol    = ({4'b0, i_in.data.pos_x} < eff_x) && ({4'b0, i_in.data.pos_y} < eff_y)
                    && ({4'b0, i_in.data.pos_z} < eff_z);
    assign host_addr = {AW'(i_in.data.pos_x), AW'(i_in.data.pos_y), AW'(i_in.data.pos_z)};
    assign slot_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_st == T_IDLE) && slot_free;
    assign acc_in    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 6'd32;
            r_size_y <= 6'd32;
            r_size_z <= 6'd32;
            r_radius <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                CFG_RADIUS: r_radius <= i_cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        n_st  = r_st;
        n_ov  = r_ov && !o_out.ready;
        n_out = r_out;
        unique case (r_st)
            T_IDLE: begin
                if (acc_in) begin
                    unique case (i_in.data.mode)
                        MODE_WRITE: begin
                            n_ov  = 1'b1;
                            n_out = '{update_flag: 1'b0, coord_error: !in_vol};
                        end
                        MODE_COMPUTE: n_st = T_COMP;
                        MODE_READ:    n_st = T_READ;
                        default: begin
                            n_ov  = 1'b1;
                            n_out = '0;
                        end
                    endcase
                end
            end
            T_COMP: if (seq_done) n_st = T_CEND;
            T_CEND: begin
                if (slot_free) begin
                    n_ov  = 1'b1;
                    n_out = '0;
                    n_st  = T_IDLE;
                end
            end
            T_READ: begin
                if (slot_free) begin
                    n_ov  = 1'b1;
                    n_out = '{update_flag: r_rd_in & r_map_ok & map_q[PASS_X],
                              coord_error: !r_rd_in};
                    n_st  = T_IDLE;
                end
            end
            default: n_st = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= T_IDLE;
            r_ov     <= 1'b0;
            r_map_ok <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            if (seq_done) begin
                r_map_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (acc_in) begin
            r_rd_in <= in_vol;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    zcbm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (acc_in && i_in.data.mode == MODE_COMPUTE),
        .i_eff_x  (eff_x),
        .i_eff_y  (eff_y),
        .i_eff_z  (eff_z),
        .i_radius (r_radius),
        .o_done   (seq_done),
        .o_ctl    (seq_ctl),
        .o_raddr  (seq_raddr),
        .o_waddr  (seq_waddr),
        .o_wdata  (seq_wdata),
        .i_dist_q (dist_q),
        .i_map_q  (map_q)
    );

    always_comb begin
        mem_ctl         = seq_ctl;
        mem_ctl.dist_we = acc_in && i_in.data.mode == MODE_WRITE && in_vol;
        mem_ctl.map_re  = seq_ctl.map_re || (acc_in && i_in.data.mode == MODE_READ && in_vol);
    end

    zcbm_store #(.VA(VA)) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_dist_waddr (host_addr),
        .i_dist_wdata (dist_of(i_in.data.sample)),
        .i_dist_raddr (seq_raddr),
        .o_dist_q     (dist_q),
        .i_map_waddr  (seq_waddr),
        .i_map_wdata  (seq_wdata),
        .i_map_raddr  ((r_st == T_COMP) ? seq_raddr : host_addr),
        .o_map_q      (map_q)
    );

`ifndef ASSERT_OFF
    a_sweep_only_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_ctl.map_we || seq_ctl.map_re || seq_ctl.dist_re) |-> r_st == T_COMP)
        else $error("sweep touches memory outside a compute");

    a_done_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> r_st == T_COMP)
        else $error("sweep finished with no compute pending");

    a_read_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == T_READ && $past(r_st) == T_IDLE && r_rd_in)
        |-> $past(mem_ctl.map_re))
        else $error("flag read without a memory read");
`endif

endmodule
